/* rtl/core/tks_pkg.sv */
`timescale 1ns / 1ps

package tks_pkg;

  localparam int RANKS   = 8;
  localparam int SCORE_W = 32;
  localparam int RANK_W  = 7;
  localparam int IDX_W   = (RANKS > 1) ? $clog2(RANKS) : 1;

  localparam logic ACT_READ   = 1'b0;
  localparam logic ACT_SUBMIT = 1'b1;

  // Token that walks down the chain of cells during an insertion.
  typedef struct packed {
    logic                      tok;
    logic                      found;
    logic [RANK_W-1:0]         rank;
    logic signed [SCORE_W-1:0] carry;
  } tks_link_t;

endpackage

/* rtl/core/tks_if.sv */
`timescale 1ns / 1ps

interface tks_req_if;
  import tks_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [SCORE_W-1:0] score;

  modport source (output valid, output action, output score, input ready);
  modport sink   (input valid, input action, input score, output ready);
endinterface

interface tks_rsp_if;
  import tks_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] entry_score;
  logic [RANK_W-1:0]         rank;
  logic                      last;

  modport source (output valid, output entry_score, output rank, output last, input ready);
  modport sink   (input valid, input entry_score, input rank, input last, output ready);
endinterface

/* rtl/core/tks_cell.sv */
`timescale 1ns / 1ps

module tks_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [tks_pkg::RANK_W-1:0]         idx_i,
  input  logic signed [tks_pkg::SCORE_W-1:0] score_i,
  input  logic                               rot_i,
  input  logic signed [tks_pkg::SCORE_W-1:0] nb_val_i,
  input  tks_pkg::tks_link_t                 link_i,
  output tks_pkg::tks_link_t                 link_o,
  output logic signed [tks_pkg::SCORE_W-1:0] val_o
);
  import tks_pkg::*;

  logic signed [SCORE_W-1:0] val_q, val_d;
  tks_link_t                 link_q, link_d;
  logic                      swap;
  logic                      eq;

  always_comb begin
    swap   = val_q < link_i.carry;
    val_d  = val_q;
    link_d = link_i;
    eq     = 1'b0;
    if (rot_i) begin
      val_d = nb_val_i;
    end else if (link_i.tok) begin
      val_d        = swap ? link_i.carry : val_q;
      link_d.carry = swap ? val_q : link_i.carry;
      eq           = (val_d == score_i);
      link_d.found = link_i.found | eq;
      // Keep the first match found further up the chain.
      if (!link_i.found) begin
        link_d.rank = eq ? idx_i + RANK_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      link_q <= '0;
    end else begin
      val_q  <= val_d;
      link_q <= link_d;
    end
  end

  assign link_o = link_q;
  assign val_o  = val_q;

endmodule

/* rtl/core/top_k_score_table.sv */
// Channel  Port   Dir  Payload                     Role
// request  req_i  in   action, score               read table / submit score
// result   rsp_o  out  entry_score, rank, last     table entries or submit rank
//
// A submit walks the score one cell per cycle down the chain, then its rank
// is moved into the output register. A read gives RANKS items, one per cycle
// while the result is not stalled, as the chain rotates past cell 0.
// Reset clears every entry to zero at once. A stalled result holds the
// output register; the next request is taken as soon as the block is idle.
`timescale 1ns / 1ps

module top_k_score_table (
  input  logic   clk_i,
  input  logic   rst_ni,
  tks_req_if.sink   req_i,
  tks_rsp_if.source rsp_o
);
  import tks_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUBMIT,
    ST_SUB_OUT,
    ST_READ
  } state_e;

  state_e                    state_q;
  logic [IDX_W-1:0]          cnt_q;
  logic signed [SCORE_W-1:0] score_q;
  logic [RANK_W-1:0]         rank_hold_q;
  tks_link_t                 head_q;

  logic                      out_valid_q;
  logic signed [SCORE_W-1:0] out_score_q;
  logic [RANK_W-1:0]         out_rank_q;
  logic                      out_last_q;

  // Chain wiring: link[i] enters cell i, link[RANKS] leaves the last cell.
  tks_link_t                 link [RANKS+1];
  logic signed [SCORE_W-1:0] val  [RANKS];
  logic [RANKS-1:0]          tok_vec;

  logic out_free;
  logic out_load;
  logic rotate;
  logic accept;
  logic cnt_last;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  // A new result enters the output register in these cycles.
  assign out_load = ((state_q == ST_SUB_OUT) || (state_q == ST_READ)) && out_free;
  // During a read the whole chain shifts toward cell 0 once per delivered item;
  // after RANKS shifts every entry is back in its own cell.
  assign rotate   = (state_q == ST_READ) && out_free;
  assign cnt_last = (cnt_q == IDX_W'(RANKS - 1));

  assign link[0] = head_q;

  for (genvar i = 0; i < RANKS; i++) begin : g_cell
    tks_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (RANK_W'(i)),
      .score_i  (score_q),
      .rot_i    (rotate),
      .nb_val_i (val[(i + 1) % RANKS]),
      .link_i   (link[i]),
      .link_o   (link[i+1]),
      .val_o    (val[i])
    );
    assign tok_vec[i] = link[i].tok;
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.entry_score = out_score_q;
  assign rsp_o.rank        = out_rank_q;
  assign rsp_o.last        = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      head_q.tok  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // The insertion token is launched into cell 0 for one cycle only.
      head_q.tok  <= accept && (req_i.action == ACT_SUBMIT);
      out_valid_q <= out_load || (out_valid_q && !rsp_o.ready);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            if (req_i.action == ACT_SUBMIT) begin
              head_q.found <= 1'b0;
              head_q.rank  <= '0;
              head_q.carry <= req_i.score;
              score_q      <= req_i.score;
              state_q      <= ST_SUBMIT;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_SUBMIT: begin
          if (link[RANKS].tok) begin
            rank_hold_q <= link[RANKS].found ? link[RANKS].rank : '0;
            state_q     <= ST_SUB_OUT;
          end
        end
        ST_SUB_OUT: begin
          if (out_free) begin
            out_score_q <= '0;
            out_rank_q  <= rank_hold_q;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_score_q <= val[0];
            out_rank_q  <= RANK_W'(cnt_q) + RANK_W'(1);
            out_last_q  <= cnt_last;
            cnt_q       <= cnt_q + IDX_W'(1);
            if (cnt_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // At most one insertion token is ever in flight along the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_vec))
    else $error("more than one insertion token in the chain");

  // The chain never rotates while an insertion token is moving.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rotate |-> (tok_vec == '0))
    else $error("rotation during insertion");

  // The token only reaches the end of the chain while a submit is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   link[RANKS].tok |-> (state_q == ST_SUBMIT))
    else $error("insertion token outside of a submit");

  // An accepted request always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> (state_q != ST_IDLE))
    else $error("request accepted without starting work");

endmodule
